// ===== design/rpa_pkg.sv =====
// Shared types and codes for the reference-counted page allocator.
// No dependencies; every other file of the block but rpa_queue uses this package.
package rpa_pkg;

	// Requested operation, as carried by the request channel.
	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_ADDREF = 2'd2,
		ACT_INIT   = 2'd3
	} action_t;

	// Completion code returned with every result item.
	typedef enum logic [2:0] {
		RS_DONE     = 3'd0,
		RS_HELD     = 3'd1,
		RS_OOM      = 3'd2,
		RS_BADADDR  = 3'd3,
		RS_DOUBLE   = 3'd4,
		RS_OVERFLOW = 3'd5
	} status_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 4'd1;

	localparam int ADDR_W  = 32;
	localparam int PAGES_W = 16;
	localparam int AFTER_W = 16;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		action_t action;
		logic    bad;
	} cmd_t;

endpackage

// ===== design/rpa_if.sv =====
// Handshake channels of the page allocator: request, result and configuration write.
// Depends on rpa_pkg for field widths.
interface rpa_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [rpa_pkg::ADDR_W-1:0] page_addr;

	modport source (output valid, action, page_addr, input ready);
	modport sink   (input valid, action, page_addr, output ready);
endinterface

interface rpa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rpa_pkg::ADDR_W-1:0]  granted_addr;
	logic [2:0]                 status;
	logic [rpa_pkg::AFTER_W-1:0] ref_after;

	modport source (output valid, granted_addr, status, ref_after, input ready);
	modport sink   (input valid, granted_addr, status, ref_after, output ready);
endinterface

interface rpa_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rpa_pkg::CFG_IDX_W-1:0] index;
	logic [rpa_pkg::ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rpa_queue.sv =====
// Short FIFO that decouples the allocator front end from its back end.
// Depends on nothing but its parameters.
module rpa_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	output logic         pop_valid,
	output logic [W-1:0] pop_data,
	input  logic         pop
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== design/rpa_front.sv =====
// Front end of the page allocator: accepts request items and checks the page address.
// Depends on rpa_pkg and the request channel interface.
module rpa_front #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	rpa_req_if.sink                          req,
	input  logic [rpa_pkg::ADDR_W-1:0]       base_al,
	input  logic [$clog2(NUM_PAGES+1)-1:0]   active,
	input  logic                             q_ready,
	output logic                             q_push,
	output rpa_pkg::cmd_t                    cmd,
	output logic [$clog2(NUM_PAGES)-1:0]     idx
);
	import rpa_pkg::*;

	localparam int IW  = $clog2(NUM_PAGES);
	localparam int FCW = $clog2(NUM_PAGES + 1);
	localparam int PW  = ADDR_W - PAGE_SHIFT;
	localparam int XW  = (PW > FCW) ? PW : FCW;

	logic [ADDR_W-1:0] diff;
	logic [XW-1:0]     page_x;
	logic              misaligned;

	assign req.ready = q_ready;
	assign q_push    = req.valid && q_ready;

	// The page index is the offset from the aligned base in whole pages.
	assign diff       = req.page_addr - base_al;
	assign page_x     = XW'(diff[ADDR_W-1:PAGE_SHIFT]);
	assign misaligned = (req.page_addr[PAGE_SHIFT-1:0] != '0);

	always_comb begin
		cmd.action = action_t'(req.action);
		cmd.bad    = misaligned || (req.page_addr < base_al) || (page_x >= XW'(active));
		idx        = page_x[IW-1:0];
	end
endmodule

// ===== design/rpa_back.sv =====
// Back end of the page allocator: free stack, reference count memory and result register.
// Depends on rpa_pkg and the result channel interface.
module rpa_back #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int REF_WIDTH  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rpa_pkg::ADDR_W-1:0]     base_al,
	input  logic [$clog2(NUM_PAGES+1)-1:0] active,
	input  logic                           q_valid,
	input  rpa_pkg::cmd_t                  q_cmd,
	input  logic [$clog2(NUM_PAGES)-1:0]   q_idx,
	output logic                           q_pop,
	rpa_rsp_if.source                      rsp
);
	import rpa_pkg::*;

	localparam int IW  = $clog2(NUM_PAGES);
	localparam int FCW = $clog2(NUM_PAGES + 1);
	localparam int XRW = (REF_WIDTH > AFTER_W) ? REF_WIDTH : AFTER_W;
	localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ALLOC = 2'd1;
	localparam logic [1:0] S_RMW   = 2'd2;
	localparam logic [1:0] S_INIT  = 2'd3;

	logic [1:0]           state_q;
	action_t              act_q;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        cnt_q;
	logic [FCW-1:0]       fc_q;

	logic [IW-1:0]        stack_mem_q [NUM_PAGES];
	logic [REF_WIDTH-1:0] ref_mem_q   [NUM_PAGES];
	logic [IW-1:0]        stk_rd_q;
	logic [REF_WIDTH-1:0] ref_rd_q;

	logic                 rsp_valid_q;
	logic [ADDR_W-1:0]    granted_q;
	status_t              status_q;
	logic [AFTER_W-1:0]   after_q;

	logic                 out_free;
	logic                 stk_we, stk_re, ref_we, ref_re;
	logic [IW-1:0]        stk_waddr, stk_wdata, stk_raddr, ref_waddr, ref_raddr;
	logic [REF_WIDTH-1:0] ref_wdata;
	logic [REF_WIDTH-1:0] cnt_dec, cnt_inc;
	logic [XRW-1:0]       dec_x, rd_x, inc_x;
	logic [FCW-1:0]       fc_dec;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid && out_free;
	assign fc_dec   = fc_q - 1'b1;
	assign cnt_dec  = ref_rd_q - 1'b1;
	assign cnt_inc  = ref_rd_q + 1'b1;
	assign dec_x    = XRW'(cnt_dec);
	assign inc_x    = XRW'(cnt_inc);
	assign rd_x     = XRW'(ref_rd_q);

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted_addr = granted_q;
	assign rsp.status       = status_q;
	assign rsp.ref_after    = after_q;

	// Memory port controls.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = cnt_q;
		stk_wdata = cnt_q;
		stk_re    = 1'b0;
		stk_raddr = fc_dec[IW-1:0];
		ref_we    = 1'b0;
		ref_waddr = idx_q;
		ref_wdata = '0;
		ref_re    = 1'b0;
		ref_raddr = q_idx;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					stk_re = (q_cmd.action == ACT_ALLOC) && (fc_q != '0);
					ref_re = ((q_cmd.action == ACT_FREE) || (q_cmd.action == ACT_ADDREF))
						&& !q_cmd.bad;
				end
			end
			S_ALLOC: begin
				ref_we    = 1'b1;
				ref_waddr = stk_rd_q;
				ref_wdata = REF_WIDTH'(1);
			end
			S_RMW: begin
				if (act_q == ACT_FREE) begin
					ref_we    = (ref_rd_q != '0);
					ref_wdata = cnt_dec;
					stk_we    = (ref_rd_q != '0) && (cnt_dec == '0)
						&& (fc_q < FCW'(NUM_PAGES));
					stk_waddr = fc_q[IW-1:0];
					stk_wdata = idx_q;
				end else begin
					ref_we    = (ref_rd_q != REF_MAX);
					ref_wdata = cnt_inc;
				end
			end
			S_INIT: begin
				stk_we    = 1'b1;
				ref_we    = 1'b1;
				ref_waddr = cnt_q;
				ref_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem_q[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_q <= stack_mem_q[stk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem_q[ref_waddr] <= ref_wdata;
		end
		if (ref_re) begin
			ref_rd_q <= ref_mem_q[ref_raddr];
		end
	end

	// Payload of the command in flight.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			act_q <= q_cmd.action;
			idx_q <= q_idx;
		end
	end

	// Result payload; the slot is known to be free whenever a result is written.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					granted_q <= '0;
					after_q   <= '0;
					if (q_cmd.action == ACT_ALLOC) begin
						status_q <= RS_OOM;
					end else if (q_cmd.action == ACT_INIT) begin
						status_q <= RS_DONE;
					end else begin
						status_q <= RS_BADADDR;
					end
				end
			end
			S_ALLOC: begin
				granted_q <= base_al + (ADDR_W'(stk_rd_q) << PAGE_SHIFT);
				status_q  <= RS_DONE;
				after_q   <= AFTER_W'(1);
			end
			S_RMW: begin
				granted_q <= '0;
				if (act_q == ACT_FREE) begin
					if (ref_rd_q == '0) begin
						status_q <= RS_DOUBLE;
						after_q  <= '0;
					end else begin
						status_q <= (cnt_dec != '0) ? RS_HELD : RS_DONE;
						after_q  <= dec_x[AFTER_W-1:0];
					end
				end else begin
					if (ref_rd_q == REF_MAX) begin
						status_q <= RS_OVERFLOW;
						after_q  <= rd_x[AFTER_W-1:0];
					end else begin
						status_q <= RS_DONE;
						after_q  <= inc_x[AFTER_W-1:0];
					end
				end
			end
			S_INIT: begin
				granted_q <= '0;
				status_q  <= RS_DONE;
				after_q   <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fc_q        <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						priority case (q_cmd.action)
							ACT_INIT: begin
								cnt_q <= '0;
								if (active == '0) begin
									fc_q        <= '0;
									rsp_valid_q <= 1'b1;
								end else begin
									state_q <= S_INIT;
								end
							end
							ACT_ALLOC: begin
								if (fc_q == '0) begin
									rsp_valid_q <= 1'b1;
								end else begin
									fc_q    <= fc_dec;
									state_q <= S_ALLOC;
								end
							end
							default: begin
								if (q_cmd.bad) begin
									rsp_valid_q <= 1'b1;
								end else begin
									state_q <= S_RMW;
								end
							end
						endcase
					end
				end
				S_ALLOC: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_RMW: begin
					if (stk_we) begin
						fc_q <= fc_q + 1'b1;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_INIT: begin
					if (FCW'(cnt_q) == active - 1'b1) begin
						fc_q        <= active;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== design/refcounted_page_allocator_core.sv =====
// Top level of the reference-counted page allocator: configuration registers and wiring.
// Depends on rpa_pkg, the channel interfaces, rpa_front, rpa_queue and rpa_back.

// This block hands out pages of (1 << PAGE_SHIFT) bytes from a pool that starts at the
// pool_base register and holds pool_pages pages (clamped to NUM_PAGES), and keeps a
// reference count for each page. An init item stacks every pool page on the free stack,
// highest page on top, and clears its count; alloc pops the top page and returns its
// address with a count of one; free decrements and returns the page to the stack at
// zero; add reference increments with saturation. Every request item returns exactly
// one result item, in order. Misaligned or out-of-pool addresses, double frees and
// saturating increments are reported in the status field and change nothing. A request
// passes the address check in the front end and then waits in a two-entry queue, so
// the request side keeps accepting, until the queue is full, while the back end works
// or while a result waits to be taken. In the back end, alloc, free and add reference
// read the free stack or the count memory as the item leaves the queue, then write the
// count memory and load the result register in the S_ALLOC or S_RMW state. Out of
// memory and bad address results are loaded as the item leaves the queue. Init then
// walks the pool pages in S_INIT and writes one stack entry and one count per cycle
// through the memories' single write ports. No clearing pass runs after reset: the
// count memory is defined only for pages covered by an init, and the free stack is
// empty out of reset. Configuration writes are always accepted and must only be issued
// while no request is in flight.
module refcounted_page_allocator_core #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int REF_WIDTH  = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	rpa_cfg_if.sink  cfg,
	rpa_req_if.sink  req,
	rpa_rsp_if.source rsp
);
	import rpa_pkg::*;

	localparam int IW  = $clog2(NUM_PAGES);
	localparam int FCW = $clog2(NUM_PAGES + 1);
	localparam int CW  = (FCW > PAGES_W) ? FCW : PAGES_W;
	localparam int QW  = $bits(cmd_t) + IW;

	logic [ADDR_W-1:0]  pool_base_q;
	logic [PAGES_W-1:0] pool_pages_q;
	logic [ADDR_W-1:0]  base_al;
	logic [CW-1:0]      pages_x;
	logic [CW-1:0]      active_x;
	logic [FCW-1:0]     active;

	logic               f_push, q_ready, q_valid, q_pop;
	cmd_t               f_cmd, b_cmd;
	logic [IW-1:0]      f_idx, b_idx;
	logic [QW-1:0]      q_out;

	// Configuration registers. Writes to unknown indexes are accepted and ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= 32'd2147753984;
			pool_pages_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_POOL_BASE) begin
				pool_base_q <= cfg.data;
			end else if (cfg.index == REG_POOL_PAGES) begin
				pool_pages_q <= cfg.data[PAGES_W-1:0];
			end
		end
	end

	// The low page-offset bits of the base are ignored, and a pool larger than the
	// memories is clamped to their size.
	assign base_al  = {pool_base_q[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign pages_x  = CW'(pool_pages_q);
	assign active_x = (pages_x > CW'(NUM_PAGES)) ? CW'(NUM_PAGES) : pages_x;
	assign active   = active_x[FCW-1:0];

	rpa_front #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_front (
		.req    (req),
		.base_al(base_al),
		.active (active),
		.q_ready(q_ready),
		.q_push (f_push),
		.cmd    (f_cmd),
		.idx    (f_idx)
	);

	rpa_queue #(
		.W    (QW),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_cmd, f_idx}),
		.push_ready(q_ready),
		.pop_valid (q_valid),
		.pop_data  (q_out),
		.pop       (q_pop)
	);

	assign b_cmd = cmd_t'(q_out[QW-1:IW]);
	assign b_idx = q_out[IW-1:0];

	rpa_back #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT),
		.REF_WIDTH (REF_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.base_al(base_al),
		.active (active),
		.q_valid(q_valid),
		.q_cmd  (b_cmd),
		.q_idx  (b_idx),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);
endmodule

// ===== design/rpa_checker.sv =====
// Port-level assertions for the page allocator and the bind that attaches them.
// Depends on rpa_pkg and on refcounted_page_allocator_core.
module rpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] granted_addr,
	input logic [2:0]  status,
	input logic [15:0] ref_after
);
	import rpa_pkg::*;

	// A stalled result item holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_addr)
			&& $stable(status) && $stable(ref_after))
		else $error("result item changed while stalled");

	// Only a successful alloc grants an address.
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != RS_DONE) |-> granted_addr == '0)
		else $error("address granted with a failing status");

	// A granted page always starts with a single reference.
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (granted_addr != '0) |-> (status == RS_DONE) && (ref_after == 16'd1))
		else $error("granted page without a count of one");

	// Failures that touch no page report a zero count.
	a_zero_after: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((status == RS_OOM) || (status == RS_BADADDR) || (status == RS_DOUBLE))
			|-> ref_after == '0)
		else $error("nonzero count on a failure that touches no page");

	// A free that leaves the page referenced reports the remaining count.
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == RS_HELD) |-> ref_after != '0)
		else $error("still-referenced result with a zero count");
endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.granted_addr(rsp.granted_addr),
	.status      (rsp.status),
	.ref_after   (rsp.ref_after)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for refcounted_page_allocator_core: a page ledger mirrors the pool and
// checks every result item in order. Depends on rpa_pkg, the rpa channel interfaces and the core.

import rpa_pkg::*;

// Mirror of the allocator: configuration, free stack, reference counts and the queue of
// outcomes still owed by the block.
class page_ledger;
	localparam int NPG = 32768;
	localparam int SHIFT = 12;
	localparam logic [15:0] REF_MAX = 16'hFFFF;

	typedef struct {
		logic [31:0] granted;
		status_t     status;
		logic [15:0] after;
	} outcome_t;

	logic [31:0] pool_base;
	logic [15:0] pool_pages;
	int unsigned stack_top;
	int unsigned free_stack [NPG];
	logic [15:0] counts [NPG];
	bit          written [NPG];
	int          granted_q [$];
	outcome_t    outcome_q [$];
	int          errors;
	int          requests;
	int          results;
	int          by_status [6];

	function new();
		pool_base = 32'h8004_2000;
		pool_pages = 16'd0;
		stack_top = 0;
		errors = 0;
		requests = 0;
		results = 0;
		foreach (by_status[i]) by_status[i] = 0;
		foreach (counts[i]) counts[i] = 16'd0;
	endfunction

	function logic [31:0] base_aligned();
		return pool_base & ~((32'd1 << SHIFT) - 32'd1);
	endfunction

	function int unsigned active();
		return (pool_pages > NPG) ? NPG : pool_pages;
	endfunction

	function logic [31:0] page_address(int unsigned idx);
		return base_aligned() + (32'(idx) << SHIFT);
	endfunction

	// A page is addressable when aligned, at or above the base and inside the pool.
	function bit locate(logic [31:0] addr, output int unsigned idx);
		logic [31:0] base, offs;
		base = base_aligned();
		idx = 0;
		if ((addr & ((32'd1 << SHIFT) - 32'd1)) != 32'd0 || addr < base)
			return 0;
		offs = (addr - base) >> SHIFT;
		if (offs >= active())
			return 0;
		idx = offs;
		return 1;
	endfunction

	// True when the request would read the count of a page that was never written.
	function bit touches_unwritten(action_t act, logic [31:0] addr);
		int unsigned idx;
		if (act != ACT_FREE && act != ACT_ADDREF)
			return 0;
		if (!locate(addr, idx))
			return 0;
		return !written[idx];
	endfunction

	// Picks a page that some alloc handed out and that still holds references, or -1.
	function int take_held();
		int k, idx;
		repeat (6) begin
			if (granted_q.size() == 0)
				return -1;
			k = $urandom_range(granted_q.size() - 1);
			idx = granted_q[k];
			if (counts[idx] != 16'd0)
				return idx;
			granted_q.delete(k);
		end
		return -1;
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
		if (index == REG_POOL_BASE)
			pool_base = data;
		else if (index == REG_POOL_PAGES)
			pool_pages = data[15:0];
	endfunction

	function void book_request(action_t act, logic [31:0] addr);
		outcome_t got;
		int unsigned idx, n;
		got.granted = 32'd0;
		got.status = RS_DONE;
		got.after = 16'd0;
		idx = 0;
		requests++;
		case (act)
			ACT_INIT: begin
				n = active();
				for (int unsigned i = 0; i < n; i++) begin
					free_stack[i] = i;
					counts[i] = 16'd0;
					written[i] = 1'b1;
				end
				stack_top = n;
			end
			ACT_ALLOC: begin
				if (stack_top == 0) begin
					got.status = RS_OOM;
				end else begin
					stack_top--;
					idx = free_stack[stack_top] % NPG;
					counts[idx] = 16'd1;
					written[idx] = 1'b1;
					granted_q.push_back(idx);
					got.granted = page_address(idx);
					got.after = 16'd1;
				end
			end
			default: begin
				if (!locate(addr, idx)) begin
					got.status = RS_BADADDR;
				end else if (act == ACT_FREE) begin
					if (counts[idx] == 16'd0) begin
						got.status = RS_DOUBLE;
					end else begin
						counts[idx]--;
						got.after = counts[idx];
						if (got.after != 16'd0) begin
							got.status = RS_HELD;
						end else if (stack_top < NPG) begin
							free_stack[stack_top] = idx;
							stack_top++;
						end
					end
				end else begin
					if (counts[idx] == REF_MAX)
						got.status = RS_OVERFLOW;
					else
						counts[idx]++;
					got.after = counts[idx];
				end
			end
		endcase
		outcome_q.push_back(got);
	endfunction

	function void report(string field, logic [31:0] want, logic [31:0] seen);
		errors++;
		if (errors <= 100)
			$display("%0t: %s expected %h actual %h", $time, field, want, seen);
		else if (errors == 101)
			$display("%0t: further mismatches are counted but not shown", $time);
	endfunction

	function void match_result(logic [31:0] granted, logic [2:0] status, logic [15:0] after);
		outcome_t want;
		if (outcome_q.size() == 0) begin
			report("unexpected result, granted_addr", 32'hx, granted);
			return;
		end
		want = outcome_q.pop_front();
		results++;
		by_status[want.status]++;
		if (granted !== want.granted)
			report("granted_addr", want.granted, granted);
		if (status !== 3'(want.status))
			report("status", 32'(want.status), 32'(status));
		if (after !== want.after)
			report("ref_after", 32'(want.after), 32'(after));
	endfunction

	function int pending();
		return outcome_q.size();
	endfunction
endclass

module testbench;
	localparam int NUM_PAGES = 32768;
	localparam int PAGE_SHIFT = 12;
	// Longest silence of a correct run is an init over the full pool; the limit sits well
	// above that and the long receiver hold.
	localparam int QUIET_LIMIT = 200000;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 700;
	// An index that names no register; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

	logic clk;
	logic arst_n;

	rpa_cfg_if cfg_ch ();
	rpa_req_if req_ch ();
	rpa_rsp_if rsp_ch ();

	refcounted_page_allocator_core #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT),
		.REF_WIDTH (16)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	page_ledger ledger = new();

	// Idle pattern of the current phase, in percent of cycles.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Bumped by the main sequence to order one long receiver hold.
	int hold_seq = 0;
	int quiet_cycles = 0;
	int segments = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: ready is decided at each falling edge. A change of hold_seq starts a
	// long stretch of back-pressure that this process counts out by itself.
	initial begin : receiver
		int seen_seq, hold_left;
		seen_seq = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result item is checked against the oldest outstanding outcome.
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			ledger.match_result(rsp_ch.granted_addr, rsp_ch.status, rsp_ch.ref_after);
	end

	// Watchdog: ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offers one request item and returns once it is accepted. Valid is left high so that
	// the next call can follow back to back; an idle gap lowers it first. A free or add
	// reference that would read a never-written count is turned into an alloc.
	task automatic send_req(action_t act, logic [31:0] addr);
		int gap;
		if (ledger.touches_unwritten(act, addr))
			act = ACT_ALLOC;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(4, 1);
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.page_addr <= addr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		ledger.book_request(act, addr);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		ledger.set_register(index, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stops offering, waits until every outstanding result has been checked, then lets the
	// back end come to rest before anything else, such as a register write, happens.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random request. Most of them are well formed (alloc, free and add reference of
	// pages that are really held); the rest run an init or probe the edges of the pool,
	// misaligned addresses, frees of pages already on the stack and plain noise.
	task automatic random_op();
		int r, idx;
		int unsigned n;
		action_t act;
		logic [31:0] addr;
		n = ledger.active();
		r = $urandom_range(99);
		act = ACT_ALLOC;
		addr = $urandom();
		if (r < 34) begin
			act = ACT_ALLOC;
		end else if (r < 70) begin
			idx = ledger.take_held();
			if (idx >= 0) begin
				act = (r < 58) ? ACT_FREE : ACT_ADDREF;
				addr = ledger.page_address(idx);
			end
		end else if (r < 73) begin
			act = ACT_INIT;
		end else if (r < 79) begin
			// Mostly pages sitting on the free stack, so these end as double frees.
			if (n > 0) begin
				act = ACT_FREE;
				addr = ledger.page_address($urandom_range(n - 1));
			end
		end else if (r < 85) begin
			// One page past the end of the pool, or one page below its base.
			act = $urandom_range(1) ? ACT_FREE : ACT_ADDREF;
			addr = $urandom_range(1) ? ledger.page_address(n) :
				ledger.base_aligned() - 32'h1000;
		end else if (r < 91) begin
			act = $urandom_range(1) ? ACT_FREE : ACT_ADDREF;
			addr = ledger.page_address($urandom_range(n)) | 32'($urandom_range(4095, 1));
		end else begin
			act = action_t'($urandom_range(3));
		end
		send_req(act, addr);
	endtask

	initial begin : main
		int sent, ops, mode, r;
		int unsigned pages;
		logic [31:0] base;

		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_POOL_BASE;
		cfg_ch.data = 32'd0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ALLOC;
		req_ch.page_addr = 32'd0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, no idling. Out of reset the stack is empty and the pool has no
		// pages: alloc runs out of memory and any address is outside the pool.
		send_req(ACT_ALLOC, 32'h0);
		send_req(ACT_FREE, 32'h8004_2000);
		settle();

		// A misaligned base near the top of memory: four pages, of which the upper two wrap
		// past 2^32 and so can be handed out but never freed or referenced.
		write_reg(REG_UNUSED, 32'hA5A5_5A5A);
		write_reg(REG_POOL_BASE, 32'hFFFF_EABC);
		write_reg(REG_POOL_PAGES, 32'd4);
		send_req(ACT_INIT, 32'hFFFF_FFFF);
		repeat (4) send_req(ACT_ALLOC, 32'h0);
		send_req(ACT_ALLOC, 32'hFFFF_FFFF);
		send_req(ACT_FREE, 32'h0000_1000);
		send_req(ACT_ADDREF, 32'hFFFF_F000);
		send_req(ACT_FREE, 32'hFFFF_F000);
		send_req(ACT_FREE, 32'hFFFF_F000);
		send_req(ACT_FREE, 32'hFFFF_F000);
		send_req(ACT_FREE, 32'hFFFF_E001);
		send_req(ACT_FREE, 32'hFFFF_D000);
		send_req(ACT_ADDREF, 32'hFFFF_FFFF);
		send_req(ACT_ALLOC, 32'h0);
		settle();

		// An oversized page count is clamped to the full pool. With the stack full, an add
		// reference and a free of a page still on the stack try a push that must be dropped.
		write_reg(REG_POOL_BASE, 32'h0000_0000);
		write_reg(REG_POOL_PAGES, 32'h0000_FFFF);
		send_req(ACT_INIT, 32'h0);
		send_req(ACT_ADDREF, 32'h0000_0000);
		send_req(ACT_FREE, 32'h0000_0000);
		send_req(ACT_FREE, 32'h0800_0000);
		send_req(ACT_FREE, 32'h07FF_F000);
		send_req(ACT_ALLOC, 32'h0);

		// One more reference on the top page, then a free that leaves it still held.
		send_req(ACT_ADDREF, 32'h07FF_F000);
		send_req(ACT_FREE, 32'h07FF_F000);
		settle();

		// Random part in segments. Each segment picks a pool, writes both registers while
		// the block is idle, runs an init and then a mix of requests. The idle pattern
		// rotates through none, sender only, receiver only and both.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = segments % 4;
			send_idle_pct = (mode == 1) ? 55 : (mode == 3) ? 15 : 0;
			recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 15 : 0;

			// Small pools dominate so that stacks empty and refill often.
			r = $urandom_range(99);
			if (r < 10)
				pages = 0;
			else if (r < 80)
				pages = $urandom_range(40, 1);
			else if (r < 95)
				pages = $urandom_range(300, 41);
			else
				pages = $urandom_range(2000, 301);

			r = $urandom_range(99);
			if (r < 50)
				base = $urandom() & 32'hFFFF_F000;
			else if (r < 70)
				base = $urandom();
			else if (r < 85)
				base = 32'hFFFF_F000 - (32'($urandom_range((pages > 0) ? pages : 1, 1) - 1) << 12);
			else
				base = 32'($urandom_range(3)) << 12;

			write_reg(REG_POOL_BASE, base);
			write_reg(REG_POOL_PAGES, {16'($urandom()), 16'(pages)});
			send_req(ACT_INIT, $urandom());

			// One segment without sender idling runs against a long receiver hold, so the
			// queue fills and the request side has to stall.
			if (segments == 4)
				hold_seq++;

			ops = $urandom_range(70, 30);
			for (int i = 0; i < ops; i++) begin
				// Once, the sender pauses mid-segment until the block has drained.
				if (segments == 5 && i == ops / 2)
					settle();
				random_op();
				sent++;
			end
			settle();
			segments++;
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();
		repeat (20) @(posedge clk);

		$display("Covered %0d request items and %0d result items: done %0d, held %0d, oom %0d,",
			ledger.requests, ledger.results, ledger.by_status[RS_DONE],
			ledger.by_status[RS_HELD], ledger.by_status[RS_OOM]);
		$display("bad address %0d, double free %0d, overflow %0d, over %0d random pools.",
			ledger.by_status[RS_BADADDR], ledger.by_status[RS_DOUBLE],
			ledger.by_status[RS_OVERFLOW], segments);
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
